// ===== src/acar_pkg.sv =====
// Shared types, widths and constants of the adaptive cubic audio resampler.
package acar_pkg;

   localparam int RING_DEPTH_DEF   = 8192;
   localparam int BLOCK_FRAMES_DEF = 160;

   localparam int SMP_W   = 16;
   localparam int VOL_W   = 7;
   localparam int TGT_W   = 13;
   localparam int RATE_W  = 26;
   localparam int PHASE_W = 24;
   localparam int CSR_W   = 13;

   localparam logic [VOL_W-1:0]  VOL_RESET  = 7'd0;
   localparam logic [VOL_W-1:0]  VOL_MAX    = 7'd100;
   localparam logic [TGT_W-1:0]  TGT_RESET  = 13'd1120;
   localparam logic [RATE_W-1:0] RATE_ONE   = 26'd16777216;
   localparam logic [11:0]       AVG_GAIN   = 12'd1311;
   localparam logic [12:0]       RATE_GAIN  = 13'd3277;
   localparam logic [18:0]       MAX_SHIFT  = 19'd251658;
   localparam logic [23:0]       RECIP_100  = 24'd41943;
   localparam int                RECIP_SHIFT = 22;

   typedef enum logic {
      CSR_VOLUME = 1'b0,
      CSR_TARGET = 1'b1
   } csr_index_type;

   typedef enum logic {
      REQ_PUSH = 1'b0,
      REQ_PULL = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic               start;
      logic               hold;
      logic [VOL_W-1:0]   vol;
      logic [PHASE_W-1:0] phase;
   } lane_cmd_type;

   typedef struct packed {
      logic                    done;
      logic signed [SMP_W-1:0] sample;
      logic signed [SMP_W-1:0] scaled;
   } lane_res_type;

endpackage

// ===== src/acar_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acar_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/acar_lane.sv =====
// One channel lane: cubic interpolation, clamp and volume scaling on a shared multiplier.
module acar_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  acar_pkg::lane_cmd_type              cmd,
   input  logic signed [acar_pkg::SMP_W-1:0]   smp [4],
   output acar_pkg::lane_res_type              res
);
   import acar_pkg::*;

   typedef enum logic [3:0] {
      L_IDLE, L_P3, L_U2, L_U2H, L_U2L, L_U1, L_U1H, L_U1L, L_W, L_VOL, L_DIV, L_FIX
   } lane_state_type;

   localparam int MA_W   = 26;
   localparam int PROD_W = MA_W + 25;
   localparam int U_W    = 48;

   lane_state_type state_ff, state_in;
   logic signed [17:0]       p1_ff, p1_in;
   logic signed [19:0]       p2_ff, p2_in, p3_ff, p3_in;
   logic signed [SMP_W-1:0]  b_ff, b_in, s_ff, s_in, scaled_ff, scaled_in;
   logic [PHASE_W-1:0]       t_ff, t_in;
   logic [VOL_W-1:0]         vol_ff, vol_in;
   logic signed [U_W-1:0]    u_ff, u_in, acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [22:0]              abs_ff, abs_in;
   logic                     neg_ff, neg_in, done_ff, done_in;

   logic signed [MA_W-1:0]   mul_a;
   logic [23:0]              mul_b;
   logic signed [19:0]       p1_c, p2_c, p3_c;
   logic signed [U_W-1:0]    w_c, z_c, v_c;
   logic [22:0]              prod_abs, q0_c, q_c;

   always_comb begin
      p1_c = 20'(smp[2]) - 20'(smp[0]);
      p3_c = 20'sd3 * (20'(smp[1]) - 20'(smp[2])) + 20'(smp[3]) - 20'(smp[0]);
      p2_c = (20'(smp[0]) <<< 1) - 20'sd5 * 20'(smp[1]) + (20'(smp[2]) <<< 2)
             - 20'(smp[3]);
      prod_abs = prod_ff[PROD_W-1] ? 23'(-prod_ff) : 23'(prod_ff);
      w_c = acc_ff + U_W'(prod_ff >>> 24);
      z_c = (U_W'(b_ff) <<< 25) + w_c;
      // Division by 2^25 truncating toward zero.
      v_c = z_c[U_W-1] ? ((z_c + U_W'(33554431)) >>> 25) : (z_c >>> 25);
      q0_c = 23'(prod_ff >>> RECIP_SHIFT);
      q_c = ((abs_ff - 23'(q0_c * 23'd100)) >= 23'd100) ? q0_c + 23'd1 : q0_c;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         L_P3: begin
            mul_a = MA_W'(p3_ff);
            mul_b = t_ff;
         end
         L_U2H, L_U1H: begin
            mul_a = MA_W'($signed(u_ff[U_W-1:24]));
            mul_b = t_ff;
         end
         L_U2L, L_U1L: begin
            mul_a = $signed({2'b00, u_ff[23:0]});
            mul_b = t_ff;
         end
         L_VOL: begin
            mul_a = MA_W'(s_ff);
            mul_b = {17'b0, vol_ff};
         end
         L_DIV: begin
            mul_a = $signed({3'b000, prod_abs});
            mul_b = RECIP_100;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      p3_in     = p3_ff;
      b_in      = b_ff;
      s_in      = s_ff;
      scaled_in = scaled_ff;
      t_in      = t_ff;
      vol_in    = vol_ff;
      u_in      = u_ff;
      acc_in    = acc_ff;
      abs_in    = abs_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      prod_in   = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
      case (state_ff)
         L_IDLE: begin
            if (cmd.start) begin
               p1_in  = 18'(p1_c);
               p2_in  = p2_c;
               p3_in  = p3_c;
               b_in   = smp[1];
               s_in   = smp[1];
               t_in   = cmd.phase;
               vol_in = cmd.vol;
               state_in = cmd.hold ? L_VOL : L_P3;
            end
         end
         L_P3:  state_in = L_U2;
         L_U2: begin
            u_in = (U_W'(p2_ff) <<< 24) + $signed(prod_ff[U_W-1:0]);
            state_in = L_U2H;
         end
         L_U2H: state_in = L_U2L;
         L_U2L: begin
            acc_in = $signed(prod_ff[U_W-1:0]);
            state_in = L_U1;
         end
         L_U1: begin
            u_in = (U_W'(p1_ff) <<< 24) + acc_ff + U_W'(prod_ff >>> 24);
            state_in = L_U1H;
         end
         L_U1H: state_in = L_U1L;
         L_U1L: begin
            acc_in = $signed(prod_ff[U_W-1:0]);
            state_in = L_W;
         end
         L_W: begin
            if (v_c < -48'sd32768) begin
               s_in = -16'sd32768;
            end else if (v_c > 48'sd32767) begin
               s_in = 16'sd32767;
            end else begin
               s_in = 16'(v_c);
            end
            state_in = L_VOL;
         end
         L_VOL: state_in = L_DIV;
         L_DIV: begin
            abs_in = prod_abs;
            neg_in = prod_ff[PROD_W-1];
            state_in = L_FIX;
         end
         L_FIX: begin
            scaled_in = neg_ff ? 16'(-q_c) : 16'(q_c);
            done_in   = 1'b1;
            state_in  = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      p3_ff     <= p3_in;
      b_ff      <= b_in;
      s_ff      <= s_in;
      scaled_ff <= scaled_in;
      t_ff      <= t_in;
      vol_ff    <= vol_in;
      u_ff      <= u_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      abs_ff    <= abs_in;
      neg_ff    <= neg_in;
   end

   assign res.done   = done_ff;
   assign res.sample = s_ff;
   assign res.scaled = scaled_ff;

endmodule

// ===== src/acar_rate.sv =====
// Rate control: smoothed fill average, iterative error division and rate step.
module acar_rate #(
   parameter int FILL_W = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [FILL_W-1:0]           buffered,
   input  logic [acar_pkg::TGT_W-1:0]  target,
   output logic                        done,
   output logic [acar_pkg::RATE_W-1:0] rate
);
   import acar_pkg::*;

   typedef enum logic [2:0] {
      R_IDLE, R_LOAD, R_AVG, R_FA, R_NUM, R_DIV, R_RATE, R_PR
   } rate_state_type;

   localparam int FA_W = ((FILL_W > TGT_W) ? FILL_W : TGT_W) + 16;
   localparam int NW   = FA_W + 7;
   localparam int CW   = $clog2(NW + 1);
   localparam int AP_W = FA_W + 13;
   localparam int RP_W = 28 + 14;

   rate_state_type           state_ff, state_in;
   logic [FA_W-1:0]          b16_ff, b16_in, fa_ff, fa_in;
   logic [TGT_W-1:0]         t_ff, t_in;
   logic signed [AP_W-1:0]   avg_ff, avg_in;
   logic                     neg_ff, neg_in;
   logic [NW-1:0]            quo_ff, quo_in;
   logic [TGT_W-1:0]         rem_ff, rem_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic signed [RP_W-1:0]   rp_ff, rp_in;
   logic [RATE_W-1:0]        pr_ff, pr_in;

   logic signed [FA_W:0]     num_c;
   logic [TGT_W:0]           rem_sh;
   logic                     ge_c;
   logic [18:0]              qsat_c;
   logic signed [19:0]       err_c;
   logic signed [27:0]       diff_c;

   always_comb begin
      num_c  = $signed({1'b0, fa_ff}) - $signed({1'b0, FA_W'({t_ff, 16'b0})});
      rem_sh = {rem_ff, quo_ff[NW-1]};
      ge_c   = rem_sh >= {1'b0, t_ff};
      qsat_c = (quo_ff > NW'(MAX_SHIFT)) ? MAX_SHIFT : quo_ff[18:0];
      err_c  = neg_ff ? -$signed({1'b0, qsat_c}) : $signed({1'b0, qsat_c});
      diff_c = $signed(28'(RATE_ONE) + 28'(err_c) - 28'(pr_ff));
   end

   always_comb begin
      state_in = state_ff;
      b16_in   = b16_ff;
      fa_in    = fa_ff;
      t_in     = t_ff;
      avg_in   = avg_ff;
      neg_in   = neg_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      rp_in    = rp_ff;
      pr_in    = pr_ff;
      done     = 1'b0;
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               b16_in = FA_W'({buffered, 16'b0});
               t_in   = (target == '0) ? TGT_W'(1) : target;
               state_in = R_LOAD;
            end
         end
         R_LOAD: begin
            // The first update seeds the average with the current fill.
            if (fa_ff == '0) begin
               fa_in = b16_ff;
            end
            state_in = R_AVG;
         end
         R_AVG: begin
            avg_in = AP_W'($signed({1'b0, b16_ff}) - $signed({1'b0, fa_ff}))
                     * AP_W'($signed({1'b0, AVG_GAIN}));
            state_in = R_FA;
         end
         R_FA: begin
            fa_in = FA_W'(AP_W'($signed({1'b0, fa_ff})) + (avg_ff >>> 16));
            state_in = R_NUM;
         end
         R_NUM: begin
            neg_in = num_c[FA_W];
            quo_in = {(num_c[FA_W] ? (FA_W + 1)'(-num_c) : (FA_W + 1)'(num_c)), 6'b0};
            rem_in = '0;
            cnt_in = CW'(NW);
            state_in = R_DIV;
         end
         R_DIV: begin
            rem_in = ge_c ? TGT_W'(rem_sh - {1'b0, t_ff}) : rem_sh[TGT_W-1:0];
            quo_in = {quo_ff[NW-2:0], ge_c};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = R_RATE;
            end
         end
         R_RATE: begin
            rp_in = RP_W'(diff_c) * RP_W'($signed({1'b0, RATE_GAIN}));
            state_in = R_PR;
         end
         R_PR: begin
            pr_in = RATE_W'(28'(pr_ff) + 28'(rp_ff >>> 16));
            done  = 1'b1;
            state_in = R_IDLE;
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         fa_ff    <= '0;
         pr_ff    <= RATE_ONE;
      end else begin
         state_ff <= state_in;
         fa_ff    <= fa_in;
         pr_ff    <= pr_in;
      end
      b16_ff <= b16_in;
      t_ff   <= t_in;
      avg_ff <= avg_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      rp_ff  <= rp_in;
   end

   assign rate = pr_ff;

endmodule

// ===== src/adaptive_cubic_audio_resampler_unit.sv =====
// Top level of the adaptive cubic audio resampler: ring, sequencer and lane merge.
//
// The req channel carries push and pull words. A push writes one stereo frame
// (req_tdata) into the ring unless its block was dropped or the ring is full. A
// pull returns one output frame, interpolated from four ring frames unless held or
// silent, one lane per channel, the two lane results merged into one rsp word.
// Every accepted req word yields exactly one rsp word; buffered reports the ring
// fill after the word.
// A held pull goes straight to the lanes; an interpolated pull first reads the
// ring, then runs 11 lane steps on each lane's single multiplier. A batch-start
// pull that updates the rate first waits for the rate update, whose serial error
// divider gives one quotient bit a cycle.
// One word is in flight at a time; req_tready is high only when the sequencer is
// free, and it takes a new word while the previous rsp word still waits.
// After reset the ring is cleared, one entry a cycle, over all RING_DEPTH entries
// (8192 by default); req_tready stays low meanwhile, csr writes are taken.
// A stalled receiver holds the rsp word; the next result waits behind it.
module adaptive_cubic_audio_resampler_unit #(
   parameter int RING_DEPTH   = acar_pkg::RING_DEPTH_DEF,
   parameter int BLOCK_FRAMES = acar_pkg::BLOCK_FRAMES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,  // frame_word
   input  logic [2:0]                  req_tuser,  // req_type, block_start, batch_start
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [47:0]                 rsp_tdata,  // left_out, right_out, buffered, pad
   output logic [2:0]                  rsp_tuser,  // held, silent, dropped
   input  logic                        csr_we,
   input  logic [0:0]                  csr_addr,
   input  logic [acar_pkg::CSR_W-1:0]  csr_wdata
);
   import acar_pkg::*;

   typedef enum logic [2:0] {
      T_CLEAR, T_IDLE, T_RATE, T_DECIDE, T_READ, T_LANE, T_EMIT
   } top_state_type;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam int CW = ((FW > 11) ? FW : 11) + 1;
   localparam int TW = ((FW > TGT_W) ? FW : TGT_W) + 1;

   top_state_type      state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in, wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in, rd_addr_ff, rd_addr_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic               priming_ff, priming_in, bsil_ff, bsil_in, drop_blk_ff, drop_blk_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [31:0]        last_ff, last_in;
   logic [VOL_W-1:0]   vol_ff, vol_in;
   logic [TGT_W-1:0]   tgt_ff, tgt_in;
   logic [2:0]         k_ff, k_in;
   logic [31:0]        tap_ff [4];
   logic [31:0]        tap_in [4];
   logic               hold_ff, hold_in, lane_start_ff, lane_start_in;
   logic               held_ff, held_in, silent_ff, silent_in, dropped_ff, dropped_in;
   logic [SMP_W-1:0]   res_l_ff, res_l_in, res_r_ff, res_r_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0]        rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]         rsp_tuser_ff, rsp_tuser_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [31:0]        ram_wdata, ram_rdata;
   logic               rate_start, rate_done;
   logic [RATE_W-1:0]  play_rate;
   lane_cmd_type       lane_cmd;
   lane_res_type       lane_res_l, lane_res_r;
   logic signed [SMP_W-1:0] smp_l [4];
   logic signed [SMP_W-1:0] smp_r [4];

   logic               drop_now, full_c, below_tgt;
   logic [PHASE_W+2:0] phase_sum;
   logic [AW:0]        rd_adv;
   logic [VOL_W-1:0]   vol_sat;

   acar_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   acar_rate #(.FILL_W(FW)) u_rate (
      .clock    (clock),
      .reset    (reset),
      .start    (rate_start),
      .buffered (fill_ff),
      .target   (tgt_ff),
      .done     (rate_done),
      .rate     (play_rate)
   );

   assign vol_sat = (vol_ff > VOL_MAX) ? VOL_MAX : vol_ff;
   assign lane_cmd.start = lane_start_ff;
   assign lane_cmd.hold  = hold_ff;
   assign lane_cmd.vol   = vol_sat;
   assign lane_cmd.phase = phase_ff;

   // In hold mode the lane takes its sample from the last output frame in place of the second tap.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         smp_l[i] = $signed(tap_ff[i][15:0]);
         smp_r[i] = $signed(tap_ff[i][31:16]);
      end
      if (hold_ff) begin
         smp_l[1] = $signed(last_ff[15:0]);
         smp_r[1] = $signed(last_ff[31:16]);
      end
   end

   acar_lane u_lane_l (
      .clock (clock),
      .reset (reset),
      .cmd   (lane_cmd),
      .smp   (smp_l),
      .res   (lane_res_l)
   );

   acar_lane u_lane_r (
      .clock (clock),
      .reset (reset),
      .cmd   (lane_cmd),
      .smp   (smp_r),
      .res   (lane_res_r)
   );

   assign full_c    = fill_ff >= FW'(RING_DEPTH - 4);
   assign below_tgt = TW'(fill_ff) < TW'(tgt_ff);
   assign phase_sum = (PHASE_W + 3)'(phase_ff) + (PHASE_W + 3)'(play_rate);
   assign rd_adv    = (AW + 1)'(rd_ptr_ff) + (AW + 1)'(phase_sum[PHASE_W+2:PHASE_W]);
   assign req_tready = (state_ff == T_IDLE);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_addr_in    = rd_addr_ff;
      fill_in       = fill_ff;
      priming_in    = priming_ff;
      bsil_in       = bsil_ff;
      drop_blk_in   = drop_blk_ff;
      phase_in      = phase_ff;
      last_in       = last_ff;
      vol_in        = vol_ff;
      tgt_in        = tgt_ff;
      k_in          = k_ff;
      tap_in        = tap_ff;
      hold_in       = hold_ff;
      lane_start_in = 1'b0;
      held_in       = held_ff;
      silent_in     = silent_ff;
      dropped_in    = dropped_ff;
      res_l_in      = res_l_ff;
      res_r_in      = res_r_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_ptr_ff;
      ram_wdata     = req_tdata;
      ram_raddr     = rd_addr_ff;
      rate_start    = 1'b0;
      drop_now      = drop_blk_ff;
      if (req_tuser[1]) begin
         drop_now = (CW'(fill_ff) + CW'(BLOCK_FRAMES)) > CW'(RING_DEPTH - 4);
      end

      case (state_ff)
         T_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(RING_DEPTH - 1)) begin
               state_in = T_IDLE;
            end
         end
         T_IDLE: begin
            if (req_tvalid) begin
               held_in    = 1'b0;
               silent_in  = 1'b0;
               dropped_in = 1'b0;
               res_l_in   = '0;
               res_r_in   = '0;
               if (req_kind_type'(req_tuser[0]) == REQ_PUSH) begin
                  if (req_tuser[1]) begin
                     drop_blk_in = drop_now;
                  end
                  if (drop_now || full_c) begin
                     dropped_in = 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     wr_ptr_in = (wr_ptr_ff == AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
                     fill_in   = fill_ff + FW'(1);
                  end
                  state_in = T_EMIT;
               end else if (req_tuser[2]) begin
                  if (priming_ff && below_tgt) begin
                     bsil_in  = 1'b1;
                     state_in = T_DECIDE;
                  end else begin
                     priming_in = 1'b0;
                     bsil_in    = 1'b0;
                     rate_start = 1'b1;
                     state_in   = T_RATE;
                  end
               end else begin
                  state_in = T_DECIDE;
               end
            end
         end
         T_RATE: begin
            if (rate_done) begin
               state_in = T_DECIDE;
            end
         end
         T_DECIDE: begin
            if (priming_ff || bsil_ff) begin
               silent_in = 1'b1;
               state_in  = T_EMIT;
            end else if (fill_ff < FW'(4)) begin
               held_in       = 1'b1;
               hold_in       = 1'b1;
               lane_start_in = 1'b1;
               state_in      = T_LANE;
            end else begin
               hold_in    = 1'b0;
               rd_addr_in = (rd_ptr_ff == '0) ? AW'(RING_DEPTH - 1) : rd_ptr_ff - AW'(1);
               k_in       = '0;
               state_in   = T_READ;
            end
         end
         T_READ: begin
            rd_addr_in = (rd_addr_ff == AW'(RING_DEPTH - 1)) ? '0 : rd_addr_ff + AW'(1);
            k_in = k_ff + 3'd1;
            if (k_ff != 3'd0) begin
               tap_in[0] = tap_ff[1];
               tap_in[1] = tap_ff[2];
               tap_in[2] = tap_ff[3];
               tap_in[3] = ram_rdata;
            end
            if (k_ff == 3'd4) begin
               lane_start_in = 1'b1;
               state_in      = T_LANE;
            end
         end
         T_LANE: begin
            if (lane_res_l.done) begin
               res_l_in = lane_res_l.scaled;
               res_r_in = lane_res_r.scaled;
               if (!hold_ff) begin
                  last_in  = {lane_res_r.sample, lane_res_l.sample};
                  phase_in = phase_sum[PHASE_W-1:0];
                  rd_ptr_in = (rd_adv >= (AW + 1)'(RING_DEPTH)) ?
                              AW'(rd_adv - (AW + 1)'(RING_DEPTH)) : AW'(rd_adv);
                  fill_in  = fill_ff - FW'(phase_sum[PHASE_W+2:PHASE_W]);
               end
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, 14'(fill_ff), res_r_ff, res_l_ff};
               rsp_tuser_in  = {dropped_ff, silent_ff, held_ff};
               state_in      = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase

      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_VOLUME: vol_in = csr_wdata[VOL_W-1:0];
            CSR_TARGET: tgt_in = csr_wdata[TGT_W-1:0];
            default:    vol_in = vol_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_CLEAR;
         clr_addr_ff   <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
         priming_ff    <= 1'b1;
         bsil_ff       <= 1'b0;
         drop_blk_ff   <= 1'b0;
         phase_ff      <= '0;
         last_ff       <= '0;
         vol_ff        <= VOL_RESET;
         tgt_ff        <= TGT_RESET;
         lane_start_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fill_ff       <= fill_in;
         priming_ff    <= priming_in;
         bsil_ff       <= bsil_in;
         drop_blk_ff   <= drop_blk_in;
         phase_ff      <= phase_in;
         last_ff       <= last_in;
         vol_ff        <= vol_in;
         tgt_ff        <= tgt_in;
         lane_start_ff <= lane_start_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rd_addr_ff   <= rd_addr_in;
      k_ff         <= k_in;
      tap_ff       <= tap_in;
      hold_ff      <= hold_in;
      held_ff      <= held_in;
      silent_ff    <= silent_in;
      dropped_ff   <= dropped_in;
      res_l_ff     <= res_l_in;
      res_r_ff     <= res_r_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(RING_DEPTH))
      else $error("ring fill exceeds ring depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == T_IDLE) |-> fill_ff < FW'(RING_DEPTH - 4))
      else $error("push written into a full ring");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]) && !(rsp_tuser[2] && rsp_tuser[0]))
      else $error("conflicting result flags");

   a_lanes_sync: assert property (@(posedge clock) disable iff (reset)
      lane_res_l.done == lane_res_r.done)
      else $error("channel lanes out of step");

endmodule
